// File: rtl/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 64;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  typedef enum logic [7:0] {
    ST_HUNT    = 8'b0000_0001,
    ST_SYNC2   = 8'b0000_0010,
    ST_CMD     = 8'b0000_0100,
    ST_LEN     = 8'b0000_1000,
    ST_PAYLOAD = 8'b0001_0000,
    ST_CHECK   = 8'b0010_0000,
    ST_READ    = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic capture_cmd;
    logic capture_len;
    logic store_byte;
    logic start_read;
    logic load_empty;
    logic read_mem;
    logic next_index;
  } cmd_t;

  typedef struct packed {
    logic sync_first;
    logic sync_second;
    logic len_zero;
    logic len_fits;
    logic fill_last;
    logic check_ok;
    logic held_zero;
    logic emit_last;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/sfr_ctrl.sv
`default_nettype none

module sfr_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  input  sfr_pkg::status_t sts_i,
  output sfr_pkg::cmd_t  cmd_o
);
  import sfr_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o  = (state_q == ST_READ) || (state_q == ST_EMIT);
  assign out_valid_o = (state_q == ST_EMIT);
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_HUNT: begin
        if (accept && sts_i.sync_first) begin
          state_d = ST_SYNC2;
        end
      end
      ST_SYNC2: begin
        if (accept) begin
          state_d = sts_i.sync_second ? ST_CMD : ST_HUNT;
        end
      end
      ST_CMD: begin
        if (accept) begin
          cmd_o.capture_cmd = 1'b1;
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (accept) begin
          cmd_o.capture_len = 1'b1;
          if (sts_i.len_zero) begin
            state_d = ST_CHECK;
          end else if (sts_i.len_fits) begin
            state_d = ST_PAYLOAD;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_PAYLOAD: begin
        if (accept) begin
          cmd_o.store_byte = 1'b1;
          if (sts_i.fill_last) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (accept) begin
          if (!sts_i.check_ok) begin
            state_d = ST_HUNT;
          end else if (sts_i.held_zero) begin
            cmd_o.load_empty = 1'b1;
            state_d = ST_EMIT;
          end else begin
            cmd_o.start_read = 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.read_mem = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          if (sts_i.emit_last) begin
            state_d = ST_HUNT;
          end else begin
            cmd_o.next_index = 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_EMIT))
    else $error("read cycle not followed by a result");

  a_next_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !sts_i.emit_last) |=> (state_q == ST_READ))
    else $error("frame output stopped before its last item");

  a_hunt_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && sts_i.emit_last) |=> (state_q == ST_HUNT))
    else $error("parser did not return to hunting after the last item");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sts_i.emit_last)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// File: rtl/sfr_datapath.sv
`default_nettype none

module sfr_datapath #(
  parameter int unsigned PAYLOAD_DEPTH = sfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire        [7:0] rx_byte_i,
  input  sfr_pkg::cmd_t    cmd_i,
  output sfr_pkg::status_t sts_o,
  output logic       [7:0] frame_cmd_o,
  output logic       [6:0] frame_len_o,
  output logic       [5:0] byte_index_o,
  output logic       [7:0] payload_byte_o,
  output logic             has_payload_o,
  output logic             last_o
);
  import sfr_pkg::*;

  localparam int unsigned LW = $clog2(PAYLOAD_DEPTH + 1);
  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic [7:0]    cmd_q;
  logic [LW-1:0] len_q;
  logic [7:0]    check_q;
  logic [LW-1:0] fill_q;
  logic [LW-1:0] rd_idx_q;
  logic          has_payload_q;
  logic [7:0]    rd_data_q;
  logic [7:0]    mem_q [PAYLOAD_DEPTH];
  logic [LW:0]   fill_next;
  logic [LW:0]   rd_next;

  assign fill_next = {1'b0, fill_q} + {{LW{1'b0}}, 1'b1};
  assign rd_next   = {1'b0, rd_idx_q} + {{LW{1'b0}}, 1'b1};

  assign sts_o.sync_first  = (rx_byte_i == SYNC_FIRST);
  assign sts_o.sync_second = (rx_byte_i == SYNC_SECOND);
  assign sts_o.len_zero    = (rx_byte_i == 8'd0);
  assign sts_o.len_fits    = ({1'b0, rx_byte_i} <= 9'(PAYLOAD_DEPTH));
  assign sts_o.fill_last   = (fill_next == {1'b0, len_q});
  assign sts_o.check_ok    = (rx_byte_i == check_q);
  assign sts_o.held_zero   = (len_q == '0);
  assign sts_o.emit_last   = !has_payload_q || (rd_next == {1'b0, len_q});

  assign frame_cmd_o    = cmd_q;
  assign frame_len_o    = 7'(len_q);
  assign byte_index_o   = 6'(rd_idx_q);
  assign payload_byte_o = has_payload_q ? rd_data_q : 8'd0;
  assign has_payload_o  = has_payload_q;
  assign last_o         = sts_o.emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q         <= '0;
      len_q         <= '0;
      check_q       <= '0;
      fill_q        <= '0;
      rd_idx_q      <= '0;
      has_payload_q <= 1'b0;
    end else begin
      if (cmd_i.capture_cmd) begin
        cmd_q <= rx_byte_i;
      end
      if (cmd_i.capture_len) begin
        len_q   <= LW'(rx_byte_i);
        fill_q  <= '0;
        check_q <= cmd_q ^ rx_byte_i;
      end
      if (cmd_i.store_byte) begin
        fill_q  <= fill_next[LW-1:0];
        check_q <= check_q ^ rx_byte_i;
      end
      if (cmd_i.start_read) begin
        rd_idx_q      <= '0;
        has_payload_q <= 1'b1;
      end
      if (cmd_i.load_empty) begin
        rd_idx_q      <= '0;
        has_payload_q <= 1'b0;
      end
      if (cmd_i.next_index) begin
        rd_idx_q <= rd_next[LW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) begin
      mem_q[fill_q[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.read_mem) begin
      rd_data_q <= mem_q[rd_idx_q[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

// File: rtl/sync_frame_receiver_xor_check.sv
// Each received byte is taken while in_valid_i is high and the parser is hunting or filling a frame.
// A good checksum byte leads through a payload memory read to its first result, or straight to it for an empty frame.
// Each payload result then goes through a payload memory read, then the output register, held there while stalled.
// No byte is taken while a frame is being delivered; the memory reads and out_stall_i set that pace.
// Reset clears the parser and output control; the payload memory is not cleared.
`default_nettype none

module sync_frame_receiver_xor_check #(
  parameter int unsigned PAYLOAD_DEPTH = sfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] frame_cmd_o,
  output logic [6:0] frame_len_o,
  output logic [5:0] byte_index_o,
  output logic [7:0] payload_byte_o,
  output logic       has_payload_o,
  output logic       last_o
);
  import sfr_pkg::*;

  cmd_t    cmd;
  status_t sts;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfr_datapath #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .frame_cmd_o   (frame_cmd_o),
    .frame_len_o   (frame_len_o),
    .byte_index_o  (byte_index_o),
    .payload_byte_o(payload_byte_o),
    .has_payload_o (has_payload_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
